// ===== rtl/rarp_pkg.sv =====
// Shared types and constants for the range add / range predecessor block.
// No dependencies; the top level uses it by scoped names.
package rarp_pkg;

	// Default geometry of the element array
	localparam int DEPTH_DEF     = 1024;
	localparam int BLOCK_LEN_DEF = 32;

	// Fixed field widths
	localparam int IDX_W  = 10;
	localparam int CMD_W  = 2;
	localparam int OPND_W = 32;
	localparam int VAL_W  = 64;

	// Command codes on the cmd port
	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD  = 2'd0,
		CMD_ADD   = 2'd1,
		CMD_QUERY = 2'd2
	} cmd_t;

	// Operation carried through the shared adder stage
	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_ELEM_ADD,
		OP_OFS_ADD,
		OP_QUERY
	} op_t;

endpackage

// ===== rtl/range_add_range_predecessor.sv =====
// Range add and range predecessor query over a blocked array of 64-bit values.
// Depends on rarp_pkg and rarp_ram (element store and block offset store).
//
// One command is taken when start is high and busy is low; busy stays high
// until the command is finished. Work runs through one shared 64-bit adder fed
// by the two RAM read ports, one element or one block per cycle. A range add
// handles the elements near the ends of the range one by one and the whole
// blocks in between through their block offsets. A query reads every element
// of the range once. Each query result is shown on found and best_value for
// exactly one cycle with done high; the receiver cannot stall it. After reset
// the block is busy while the block offsets are cleared.
module range_add_range_predecessor #(
	parameter int DEPTH     = rarp_pkg::DEPTH_DEF,
	parameter int BLOCK_LEN = rarp_pkg::BLOCK_LEN_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [rarp_pkg::CMD_W-1:0]          cmd,
	input  logic [rarp_pkg::IDX_W-1:0]          left_index,
	input  logic [rarp_pkg::IDX_W-1:0]          right_index,
	input  logic signed [rarp_pkg::OPND_W-1:0]  operand_value,
	output logic                                done,
	output logic                                found,
	output logic signed [rarp_pkg::VAL_W-1:0]   best_value
);

	localparam int VW = rarp_pkg::VAL_W;
	localparam int OW = rarp_pkg::OPND_W;
	localparam int NB = (DEPTH + BLOCK_LEN - 1) / BLOCK_LEN;
	localparam int IW = $clog2(DEPTH);
	localparam int BW = (NB > 1) ? $clog2(NB) : 1;
	localparam int CW = ((IW > rarp_pkg::IDX_W) ? IW : rarp_pkg::IDX_W) + 1;
	localparam int KW = $clog2(BLOCK_LEN);
	// Reciprocal for index / BLOCK_LEN, exact for 10-bit indices
	localparam int RS = 18;
	localparam int RM = ((1 << RS) + BLOCK_LEN - 1) / BLOCK_LEN;
	localparam int PW = RS + 16;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SETUP,
		ST_RUN,
		ST_DRAIN
	} state_t;

	state_t                  st_q;
	rarp_pkg::cmd_t          cmd_q;
	logic [CW-1:0]           lo_q;
	logic [CW-1:0]           hi_q;
	logic signed [VW-1:0]    x_q;
	logic                    emp_q;
	logic [CW-1:0]           i_q;
	logic [BW-1:0]           b_q;
	logic [KW-1:0]           k_q;
	rarp_pkg::op_t           op_s1;
	logic [IW-1:0]           i_s1;
	logic [BW-1:0]           b_s1;
	logic signed [VW-1:0]    sum_s2;
	logic                    vld_s2;
	logic                    fnd_q;
	logic signed [VW-1:0]    bst_q;
	logic                    done_q;

	logic [CW-1:0]           lo_in;
	logic [CW-1:0]           hi_in;
	logic [CW-1:0]           hi_clip;
	logic [PW-1:0]           prod;
	logic [CW-1:0]           blk_base;
	logic [CW-1:0]           k_calc;
	logic                    k_last;
	logic [CW:0]             span_end;
	logic                    whole_blk;
	logic                    lo_bad;

	logic [VW-1:0]           add_a;
	logic [VW-1:0]           add_b;
	logic                    add_cin;
	logic signed [VW-1:0]    sum;

	logic                    e_we;
	logic [VW-1:0]           erd;
	logic                    o_we;
	logic [BW-1:0]           o_waddr;
	logic [VW-1:0]           o_wdata;
	logic [VW-1:0]           ord;

	// Input decode: clamp right edge, block of left edge by reciprocal multiply
	assign lo_in   = CW'(left_index);
	assign hi_in   = CW'(right_index);
	assign hi_clip = (hi_in >= CW'(DEPTH)) ? CW'(DEPTH - 1) : hi_in;
	assign prod    = PW'(left_index) * PW'(RM);
	assign lo_bad  = (lo_in >= CW'(DEPTH));

	// Position inside the block, and whole-block test for range add
	assign blk_base  = CW'(b_q) * CW'(BLOCK_LEN);
	assign k_calc    = lo_q - blk_base;
	assign k_last    = (k_q == KW'(BLOCK_LEN - 1));
	assign span_end  = {1'b0, i_q} + (CW + 1)'(BLOCK_LEN - 1);
	assign whole_blk = (k_q == '0) && (i_q != lo_q) && (span_end < {1'b0, hi_q});

	// Shared adder, operands by operation in flight
	always_comb begin
		add_a   = erd;
		add_b   = x_q;
		add_cin = 1'b0;
		case (op_s1)
			rarp_pkg::OP_LOAD: begin
				add_a   = x_q;
				add_b   = ~ord;
				add_cin = 1'b1;
			end
			rarp_pkg::OP_ELEM_ADD: begin
				add_a = erd;
				add_b = x_q;
			end
			rarp_pkg::OP_OFS_ADD: begin
				add_a = ord;
				add_b = x_q;
			end
			rarp_pkg::OP_QUERY: begin
				add_a = erd;
				add_b = ord;
			end
			default: begin
				add_a = erd;
				add_b = x_q;
			end
		endcase
	end

	assign sum = add_a + add_b + VW'(add_cin);

	// Memory write controls
	assign e_we    = (op_s1 == rarp_pkg::OP_ELEM_ADD) || (op_s1 == rarp_pkg::OP_LOAD);
	assign o_we    = (st_q == ST_CLEAR) || (op_s1 == rarp_pkg::OP_OFS_ADD);
	assign o_waddr = (st_q == ST_CLEAR) ? b_q : b_s1;
	assign o_wdata = (st_q == ST_CLEAR) ? '0 : sum;

	rarp_ram #(
		.WIDTH (VW),
		.DEPTH (DEPTH),
		.AW    (IW)
	) u_elem_ram (
		.clk   (clk),
		.we    (e_we),
		.waddr (i_s1),
		.wdata (sum),
		.raddr (i_q[IW-1:0]),
		.rdata (erd)
	);

	rarp_ram #(
		.WIDTH (VW),
		.DEPTH (NB),
		.AW    (BW)
	) u_ofs_ram (
		.clk   (clk),
		.we    (o_we),
		.waddr (o_waddr),
		.wdata (o_wdata),
		.raddr (b_q),
		.rdata (ord)
	);

	// Sequencer, adder pipeline and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_CLEAR;
			cmd_q  <= rarp_pkg::CMD_LOAD;
			lo_q   <= '0;
			hi_q   <= '0;
			x_q    <= '0;
			emp_q  <= 1'b0;
			i_q    <= '0;
			b_q    <= '0;
			k_q    <= '0;
			op_s1  <= rarp_pkg::OP_NONE;
			i_s1   <= '0;
			b_s1   <= '0;
			sum_s2 <= '0;
			vld_s2 <= 1'b0;
			fnd_q  <= 1'b0;
			bst_q  <= '0;
			done_q <= 1'b0;
		end else begin
			// Query compare stage
			vld_s2 <= (op_s1 == rarp_pkg::OP_QUERY);
			sum_s2 <= sum;
			if (vld_s2 && (sum_s2 < x_q) && (!fnd_q || (bst_q < sum_s2))) begin
				bst_q <= sum_s2;
				fnd_q <= 1'b1;
			end

			// Result strobe once a query has fully drained
			done_q <= (st_q == ST_DRAIN) && (op_s1 == rarp_pkg::OP_NONE) && !vld_s2 &&
				(cmd_q == rarp_pkg::CMD_QUERY);

			case (st_q)
				// Zero the block offsets, one per cycle
				ST_CLEAR: begin
					op_s1 <= rarp_pkg::OP_NONE;
					if (b_q == BW'(NB - 1)) begin
						b_q  <= '0;
						st_q <= ST_IDLE;
					end else begin
						b_q <= b_q + 1'b1;
					end
				end

				ST_IDLE: begin
					op_s1 <= rarp_pkg::OP_NONE;
					if (start) begin
						cmd_q <= rarp_pkg::cmd_t'(cmd);
						lo_q  <= lo_in;
						hi_q  <= hi_clip;
						x_q   <= {{(VW - OW){operand_value[OW-1]}}, operand_value};
						i_q   <= lo_in;
						b_q   <= prod[RS +: BW];
						emp_q <= lo_bad ||
							((cmd != rarp_pkg::CMD_LOAD) && (lo_in > hi_clip));
						fnd_q <= 1'b0;
						bst_q <= '0;
						if ((cmd == rarp_pkg::CMD_LOAD) || (cmd == rarp_pkg::CMD_ADD) ||
							(cmd == rarp_pkg::CMD_QUERY)) begin
							st_q <= ST_SETUP;
						end
					end
				end

				// Position in block; a load issues its offset read here
				ST_SETUP: begin
					k_q <= k_calc[KW-1:0];
					if (emp_q) begin
						op_s1 <= rarp_pkg::OP_NONE;
						st_q  <= ST_DRAIN;
					end else if (cmd_q == rarp_pkg::CMD_LOAD) begin
						op_s1 <= rarp_pkg::OP_LOAD;
						i_s1  <= i_q[IW-1:0];
						b_s1  <= b_q;
						st_q  <= ST_DRAIN;
					end else begin
						op_s1 <= rarp_pkg::OP_NONE;
						st_q  <= ST_RUN;
					end
				end

				// One element or one whole block per cycle
				ST_RUN: begin
					i_s1 <= i_q[IW-1:0];
					b_s1 <= b_q;
					if ((cmd_q == rarp_pkg::CMD_ADD) && whole_blk) begin
						op_s1 <= rarp_pkg::OP_OFS_ADD;
						i_q   <= i_q + CW'(BLOCK_LEN);
						b_q   <= b_q + 1'b1;
					end else begin
						op_s1 <= (cmd_q == rarp_pkg::CMD_QUERY) ?
							rarp_pkg::OP_QUERY : rarp_pkg::OP_ELEM_ADD;
						i_q <= i_q + 1'b1;
						if (k_last) begin
							k_q <= '0;
							b_q <= b_q + 1'b1;
						end else begin
							k_q <= k_q + 1'b1;
						end
						if (i_q == hi_q) begin
							st_q <= ST_DRAIN;
						end
					end
				end

				// Let the adder and compare stages empty, then report
				ST_DRAIN: begin
					op_s1 <= rarp_pkg::OP_NONE;
					if ((op_s1 == rarp_pkg::OP_NONE) && !vld_s2) begin
						st_q <= ST_IDLE;
					end
				end

				default: begin
					op_s1 <= rarp_pkg::OP_NONE;
					st_q  <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy       = (st_q != ST_IDLE);
	assign done       = done_q;
	assign found      = fnd_q;
	assign best_value = bst_q;

endmodule

// ===== rtl/rarp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module rarp_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for range_add_range_predecessor (blocked range add / predecessor).
// Depends on rarp_pkg and the RTL top level. Expected answers come from a predictor
// that mirrors the element store and block offsets.
module testbench;
	import rarp_pkg::*;

	localparam int DEPTH      = DEPTH_DEF;
	localparam int BLOCK_LEN  = BLOCK_LEN_DEF;
	localparam int NUM_BLOCKS = (DEPTH + BLOCK_LEN - 1) / BLOCK_LEN;

	// cmd code with no meaning; the block must drop it
	localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

	typedef struct {
		logic        found;
		logic [63:0] best;
	} query_answer_t;

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [CMD_W-1:0]         cmd;
	logic [IDX_W-1:0]         left_index;
	logic [IDX_W-1:0]         right_index;
	logic signed [OPND_W-1:0] operand_value;
	logic                     done;
	logic                     found;
	logic signed [VAL_W-1:0]  best_value;

	// Mirror of the block's state
	logic [63:0] elem_store [DEPTH];
	logic [63:0] blk_ofs [NUM_BLOCKS];

	query_answer_t pending_answers[$];
	query_answer_t oldest_answer;

	int failures;
	int load_count, add_count, query_count, hit_count, reserved_count, checked_count;
	int burst_left;
	bit gaps_on;

	range_add_range_predecessor #(
		.DEPTH(DEPTH),
		.BLOCK_LEN(BLOCK_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.left_index(left_index),
		.right_index(right_index),
		.operand_value(operand_value),
		.done(done),
		.found(found),
		.best_value(best_value)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Run limit, far above the slowest legal run
	initial begin
		#20000000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic logic [63:0] effective_value(input int idx);
		return elem_store[idx] + blk_ofs[idx / BLOCK_LEN];
	endfunction

	// Update the mirrored state for one accepted beat; queue the answer of a query
	function automatic void predict_command(input logic [CMD_W-1:0] c, input int lo,
			input int hi, input logic [31:0] v);
		logic [63:0] x;
		logic [63:0] eff;
		query_answer_t ans;
		int b_lo, b_hi, last, i, b;
		x = {{32{v[31]}}, v};
		ans.found = 1'b0;
		ans.best = '0;
		if (hi >= DEPTH)
			hi = DEPTH - 1;
		case (c)
		CMD_LOAD: begin
			load_count++;
			// keep the effective value equal to the loaded one
			if (lo < DEPTH)
				elem_store[lo] = x - blk_ofs[lo / BLOCK_LEN];
		end
		CMD_ADD: begin
			add_count++;
			if (lo < DEPTH && lo <= hi) begin
				b_lo = lo / BLOCK_LEN;
				b_hi = hi / BLOCK_LEN;
				if (b_lo == b_hi) begin
					for (i = lo; i <= hi; i++)
						elem_store[i] += x;
				end else begin
					last = b_lo * BLOCK_LEN + BLOCK_LEN - 1;
					if (last > DEPTH - 1)
						last = DEPTH - 1;
					for (i = lo; i <= last; i++)
						elem_store[i] += x;
					for (i = b_hi * BLOCK_LEN; i <= hi; i++)
						elem_store[i] += x;
					for (b = b_lo + 1; b < b_hi; b++)
						blk_ofs[b] += x;
				end
			end
		end
		CMD_QUERY: begin
			query_count++;
			if (lo < DEPTH && lo <= hi) begin
				for (i = lo; i <= hi; i++) begin
					eff = effective_value(i);
					if ($signed(eff) < $signed(x) &&
							(!ans.found || $signed(ans.best) < $signed(eff))) begin
						ans.best = eff;
						ans.found = 1'b1;
					end
				end
			end
			if (ans.found)
				hit_count++;
			pending_answers.push_back(ans);
		end
		default: begin
			reserved_count++;
		end
		endcase
	endfunction

	// Present one beat, hold it until taken, then maybe pause between bursts
	task automatic send_command(input logic [CMD_W-1:0] c, input int lo, input int hi,
			input logic [31:0] v);
		start <= 1'b1;
		cmd <= c;
		left_index <= lo[IDX_W-1:0];
		right_index <= hi[IDX_W-1:0];
		operand_value <= v;
		do @(posedge clk); while (busy);
		predict_command(c, lo, hi, v);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 8);
			if (gaps_on) begin
				start <= 1'b0;
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(20, 150)) @(posedge clk);
				else
					repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	endtask

	function automatic logic [31:0] mid_value();
		return $urandom_range(0, 32'h7fff_ffff) - 32'h4000_0000;
	endfunction

	task automatic choose_range(output int lo, output int hi);
		int kind;
		kind = $urandom_range(0, 9);
		if (kind < 6) begin
			lo = $urandom_range(0, DEPTH - 1);
			hi = lo + $urandom_range(0, 70);
			if (hi > DEPTH - 1)
				hi = DEPTH - 1;
		end else if (kind < 9) begin
			lo = $urandom_range(0, DEPTH - 1);
			hi = $urandom_range(lo, DEPTH - 1);
		end else begin
			// empty range
			hi = $urandom_range(0, DEPTH - 2);
			lo = $urandom_range(hi + 1, DEPTH - 1);
		end
	endtask

	// Every element gets written before any add or query reads it
	task automatic test_fill_store();
		int i;
		logic [31:0] v;
		for (i = 0; i < DEPTH; i++) begin
			v = mid_value();
			if (i % 97 == 5)
				v = 32'h7fff_ffff;
			else if (i % 97 == 50)
				v = 32'h8000_0000;
			send_command(CMD_LOAD, i, $urandom_range(0, DEPTH - 1), v);
		end
	endtask

	task automatic test_query_bounds();
		send_command(CMD_QUERY, 0, DEPTH - 1, 32'h7fff_ffff);
		send_command(CMD_QUERY, 0, DEPTH - 1, 32'h8000_0000);
		send_command(CMD_QUERY, 0, 0, 32'h7fff_ffff);
		send_command(CMD_QUERY, DEPTH - 1, DEPTH - 1, 32'h0000_0000);
	endtask

	task automatic test_empty_ranges();
		send_command(CMD_QUERY, 9, 8, 32'h7fff_ffff);
		send_command(CMD_ADD, 600, 3, 32'h0000_1234);
		send_command(CMD_QUERY, 1, 0, 32'h7fff_ffff);
	endtask

	task automatic test_add_spans();
		// inside one block, then whole array with extreme addends, then exact blocks
		send_command(CMD_ADD, 3, 9, 32'd5);
		send_command(CMD_ADD, 0, DEPTH - 1, 32'h7fff_ffff);
		send_command(CMD_ADD, 0, DEPTH - 1, 32'h8000_0000);
		send_command(CMD_ADD, BLOCK_LEN, 4 * BLOCK_LEN - 1, -32'sd7);
		send_command(CMD_QUERY, 0, DEPTH - 1, 32'd0);
		send_command(CMD_QUERY, 30, 130, 32'd1000);
	endtask

	// A load into a block with a pending offset must read back as loaded
	task automatic test_load_over_offset();
		logic [31:0] v;
		v = mid_value();
		send_command(CMD_ADD, 40, 200, 32'd12345);
		send_command(CMD_LOAD, 100, 0, v);
		send_command(CMD_QUERY, 100, 100, v + 32'd1);
		send_command(CMD_QUERY, 96, 127, v);
	endtask

	task automatic test_extreme_values();
		send_command(CMD_LOAD, DEPTH - 1, DEPTH - 1, 32'h7fff_ffff);
		send_command(CMD_QUERY, DEPTH - 1, DEPTH - 1, 32'h7fff_ffff);
		send_command(CMD_LOAD, DEPTH - 1, 0, 32'h8000_0000);
		send_command(CMD_QUERY, 1000, DEPTH - 1, 32'h8000_0001);
	endtask

	task automatic test_reserved_command();
		send_command(CMD_RESERVED, 17, 900, 32'hdead_beef);
	endtask

	task automatic test_random_mix(input int count);
		int n, pick, lo, hi;
		logic [31:0] v;
		logic [63:0] eff;
		for (n = 0; n < count; n++) begin
			// every fourth stretch runs back to back
			gaps_on = ((n / 64) % 4) != 3;
			pick = $urandom_range(0, 99);
			choose_range(lo, hi);
			if (pick < 15) begin
				send_command(CMD_LOAD, $urandom_range(0, DEPTH - 1),
					$urandom_range(0, DEPTH - 1), mid_value());
			end else if (pick < 50) begin
				if ($urandom_range(0, 2) == 0)
					v = $urandom;
				else
					v = $urandom_range(0, 2000) - 1000;
				send_command(CMD_ADD, lo, hi, v);
			end else if (pick < 95) begin
				// bounds near a stored value hit the strict-below edge
				if (lo <= hi && $urandom_range(0, 3) != 0) begin
					eff = effective_value($urandom_range(lo, hi));
					v = eff[31:0] + $urandom_range(0, 3);
				end else begin
					v = $urandom;
				end
				send_command(CMD_QUERY, lo, hi, v);
			end else begin
				send_command(CMD_RESERVED, $urandom_range(0, DEPTH - 1),
					$urandom_range(0, DEPTH - 1), $urandom);
			end
		end
		gaps_on = 1'b1;
	endtask

	// Result checker: each done beat against the oldest expected answer
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_answers.size() == 0) begin
				$error("result beat with no query outstanding: found=%0b best_value=%0d",
					found, best_value);
				failures++;
			end else begin
				oldest_answer = pending_answers.pop_front();
				checked_count++;
				if (found !== oldest_answer.found) begin
					$error("found: expected %0b, actual %0b", oldest_answer.found, found);
					failures++;
				end
				if (best_value !== oldest_answer.best) begin
					$error("best_value: expected %0d, actual %0d",
						$signed(oldest_answer.best), best_value);
					failures++;
				end
			end
		end
	end

	initial begin
		int b;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = CMD_LOAD;
		left_index = '0;
		right_index = '0;
		operand_value = '0;
		failures = 0;
		burst_left = 1;
		gaps_on = 1'b1;
		for (b = 0; b < NUM_BLOCKS; b++)
			blk_ofs[b] = '0;
		for (b = 0; b < DEPTH; b++)
			elem_store[b] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_fill_store();
		test_query_bounds();
		test_empty_ranges();
		test_add_spans();
		test_load_over_offset();
		test_extreme_values();
		test_reserved_command();
		test_random_mix(500);

		// drain: outstanding answers, then the last command's tail
		start <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		do @(posedge clk); while (busy);
		repeat (16) @(posedge clk);

		$display("Ran %0d loads, %0d range adds, %0d queries and %0d reserved commands.",
			load_count, add_count, query_count, reserved_count);
		$display("Checked %0d answers, %0d with a predecessor found.", checked_count, hit_count);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
